// ----- sv/assert_macros.svh -----
// Assertion helpers; the enclosing module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/ddn_pkg.sv -----
package ddn_pkg;

	typedef enum logic [2:0] {
		CMD_START   = 3'd0,
		CMD_TOKEN   = 3'd1,
		CMD_RETURN  = 3'd2,
		CMD_ACK     = 3'd3,
		CMD_VISITED = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_TOKEN   = 2'd0,
		KIND_RETURN  = 2'd1,
		KIND_ACK     = 2'd2,
		KIND_VISITED = 2'd3
	} kind_t;

	localparam logic REG_IS_INITIATOR = 1'b0;
	localparam logic REG_PORT_COUNT   = 1'b1;

	localparam logic [3:0] PORT_COUNT_RESET = 4'd8;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] port;
		logic [3:0] count;
	} job_t;

endpackage

// ----- sv/ddn_ctrl.sv -----
module ddn_ctrl #(
	parameter int MAX_PORTS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic            wr_index,
	input  logic [3:0]      wr_data,
	input  logic            acc,
	input  logic [2:0]      cmd,
	input  logic [2:0]      arrival_port,
	output ddn_pkg::job_t   job
);

	localparam int PW = (MAX_PORTS < 8) ? MAX_PORTS : 8;

	logic          is_initiator_q;
	logic [3:0]    port_count_q;
	logic [PW-1:0] unvisited_q;
	logic [PW-1:0] pending_q;
	logic          visited_q;
	logic          idle_q;
	logic [2:0]    entry_q;

	logic [PW-1:0] unvisited_n;
	logic [PW-1:0] pending_n;
	logic          visited_n;
	logic          idle_n;
	logic [2:0]    entry_n;

	logic [3:0]    n_ports;
	logic [PW-1:0] all_mask;
	logic [PW-1:0] sel;
	logic          in_use;
	logic          found;
	logic [2:0]    fidx;
	logic [PW-1:0] fbit;
	ddn_pkg::job_t fwd_job;

	always_comb begin
		n_ports = (port_count_q > 4'(PW)) ? 4'(PW) : port_count_q;
		in_use  = {1'b0, arrival_port} < n_ports;
		found   = 1'b0;
		fidx    = '0;
		fbit    = '0;
		for (int i = 0; i < PW; i++) begin
			all_mask[i] = 4'(i) < n_ports;
			sel[i]      = arrival_port == 3'(i);
		end
		for (int i = PW - 1; i >= 0; i--) begin
			if (unvisited_q[i]) begin
				found = 1'b1;
				fidx  = 3'(i);
			end
		end
		for (int i = 0; i < PW; i++) begin
			fbit[i] = found && (fidx == 3'(i));
		end
		if (found) begin
			fwd_job = '{kind: ddn_pkg::KIND_TOKEN, port: fidx, count: 4'd1};
		end else if (!is_initiator_q) begin
			fwd_job = '{kind: ddn_pkg::KIND_RETURN, port: entry_q, count: 4'd1};
		end else begin
			fwd_job = '{kind: ddn_pkg::KIND_TOKEN, port: 3'd0, count: 4'd0};
		end
	end

	always_comb begin
		unvisited_n = unvisited_q;
		pending_n   = pending_q;
		visited_n   = visited_q;
		idle_n      = idle_q;
		entry_n     = entry_q;
		job         = '{kind: ddn_pkg::KIND_TOKEN, port: 3'd0, count: 4'd0};
		if (cmd == ddn_pkg::CMD_START) begin
			unvisited_n = all_mask;
			pending_n   = '0;
			visited_n   = 1'b0;
			entry_n     = 3'd0;
			idle_n      = !is_initiator_q;
			if (is_initiator_q) begin
				visited_n = 1'b1;
				pending_n = all_mask;
				job = '{kind: ddn_pkg::KIND_VISITED, port: 3'd0, count: n_ports};
			end
		end else if (cmd <= ddn_pkg::CMD_VISITED && in_use) begin
			if (cmd == ddn_pkg::CMD_RETURN) begin
				unvisited_n = unvisited_q & ~fbit;
				job         = fwd_job;
			end else if (idle_q && cmd == ddn_pkg::CMD_VISITED) begin
				unvisited_n = unvisited_q & ~sel;
				idle_n      = 1'b0;
				visited_n   = 1'b1;
				job = '{kind: ddn_pkg::KIND_ACK, port: arrival_port, count: 4'd1};
			end else if (visited_q && cmd == ddn_pkg::CMD_ACK) begin
				pending_n = pending_q & ~sel;
				if (pending_n == '0) begin
					unvisited_n = unvisited_q & ~fbit;
					job         = fwd_job;
				end
			end else if (visited_q && cmd == ddn_pkg::CMD_VISITED) begin
				pending_n   = pending_q & ~sel;
				unvisited_n = unvisited_q & ~sel;
				job = '{kind: ddn_pkg::KIND_ACK, port: arrival_port, count: 4'd1};
			end else if (cmd == ddn_pkg::CMD_TOKEN) begin
				visited_n = 1'b1;
				entry_n   = arrival_port;
				pending_n = all_mask;
				job = '{kind: ddn_pkg::KIND_VISITED, port: 3'd0, count: n_ports};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_initiator_q <= 1'b0;
			port_count_q   <= ddn_pkg::PORT_COUNT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				ddn_pkg::REG_IS_INITIATOR: is_initiator_q <= wr_data[0];
				ddn_pkg::REG_PORT_COUNT:   port_count_q   <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unvisited_q <= '0;
			pending_q   <= '0;
			visited_q   <= 1'b0;
			idle_q      <= 1'b1;
			entry_q     <= 3'd0;
		end else if (acc) begin
			unvisited_q <= unvisited_n;
			pending_q   <= pending_n;
			visited_q   <= visited_n;
			idle_q      <= idle_n;
			entry_q     <= entry_n;
		end
	end

endmodule

// ----- sv/ddn_emit.sv -----
module ddn_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  ddn_pkg::job_t push_job,
	output logic          push_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    send_kind,
	output logic [2:0]    send_port,
	output logic          last
);

	logic          job_valid_s1;
	ddn_pkg::job_t job_s1;
	ddn_pkg::kind_t kind_q;
	logic [2:0]    port_q;
	logic [3:0]    left_q;
	logic          em_done;

	assign out_valid  = left_q != 4'd0;
	assign last       = left_q == 4'd1;
	assign send_kind  = kind_q;
	assign send_port  = port_q;
	assign em_done    = !out_valid || (out_ready && last);
	assign push_ready = !job_valid_s1 || em_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (push_valid) begin
			job_valid_s1 <= 1'b1;
		end else if (em_done) begin
			job_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid) begin
			job_s1 <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= ddn_pkg::KIND_TOKEN;
			port_q <= 3'd0;
			left_q <= 4'd0;
		end else if (em_done) begin
			kind_q <= job_s1.kind;
			port_q <= job_s1.port;
			left_q <= job_valid_s1 ? job_s1.count : 4'd0;
		end else if (out_ready) begin
			port_q <= port_q + 3'd1;
			left_q <= left_q - 4'd1;
		end
	end

endmodule

// ----- sv/distributed_dfs_node.sv -----
// One node of a distributed depth-first traversal.
// Input channel (in_valid/in_ready): cmd and arrival_port, one command per beat.
// Output channel (out_valid/out_ready): send_kind and send_port, one message per
// beat; last marks the final message caused by a command. A command that
// causes no message produces no beat.
// Configuration: wr_en/wr_index/wr_data; index 0 is is_initiator, index 1 is
// port_count. Write only while the node is idle.
// A command's first message passes the job register, then the output registers.
// Throughput: one message per cycle while out_ready is high; a command
// occupies the message emitter until all its messages are sent (up to eight
// for a Visited broadcast, one otherwise). A one-entry job register ahead of
// the emitter lets the next command be taken while the current ones drain.
// Reset clears masks, flags and entry port, sets idle, is_initiator to 0 and
// port_count to 8. When the receiver stalls, the current message holds and at
// most one further command is buffered before in_ready drops.
module distributed_dfs_node #(
	parameter int MAX_PORTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic [3:0] wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] cmd,
	input  logic [2:0] arrival_port,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] send_kind,
	output logic [2:0] send_port,
	output logic       last
);

	`include "assert_macros.svh"

	logic          acc;
	ddn_pkg::job_t job;

	assign acc = in_valid && in_ready;

	ddn_ctrl #(
		.MAX_PORTS(MAX_PORTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.acc         (acc),
		.cmd         (cmd),
		.arrival_port(arrival_port),
		.job         (job)
	);

	ddn_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(acc && (job.count != 4'd0)),
		.push_job  (job),
		.push_ready(in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.send_kind (send_kind),
		.send_port (send_port),
		.last      (last)
	);

	`ASSERT_SAME(a_single_alone, out_valid && send_kind != ddn_pkg::KIND_VISITED, last)
	`ASSERT_SAME(a_stall_busy, !in_ready, out_valid)
	`ASSERT_NEXT(a_bcast_step, out_valid && out_ready && !last,
		out_valid && send_port == 3'($past(send_port) + 3'd1))

endmodule
